// ----- design/xor_framed_link_receiver_macros.svh -----
// assertion macros for the framed link receiver
`ifndef XOR_FRAMED_LINK_RECEIVER_MACROS_SVH
`define XOR_FRAMED_LINK_RECEIVER_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define XFLR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("xflr assertion failed");

// next-cycle implication, disabled while reset is high
`define XFLR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("xflr assertion failed");

`endif

// ----- design/xflr_pkg.sv -----
// shared types, codes and reset values of the framed link receiver
package xflr_pkg;

   // result kinds
   localparam logic [2:0] KIND_PAYLOAD   = 3'd0;
   localparam logic [2:0] KIND_GOOD      = 3'd1;
   localparam logic [2:0] KIND_CSUM_ERR  = 3'd2;
   localparam logic [2:0] KIND_IGNORED   = 3'd3;
   localparam logic [2:0] KIND_ACK_RX    = 3'd4;
   localparam logic [2:0] KIND_ADDR_ERR  = 3'd5;

   // receive phases
   localparam logic [2:0] PH_HUNT = 3'd0;
   localparam logic [2:0] PH_DEST = 3'd1;
   localparam logic [2:0] PH_SRC  = 3'd2;
   localparam logic [2:0] PH_TYPE = 3'd3;
   localparam logic [2:0] PH_LEN1 = 3'd4;
   localparam logic [2:0] PH_LEN2 = 3'd5;
   localparam logic [2:0] PH_BODY = 3'd6;

   // register indexes
   localparam logic [1:0] REG_FRAME_MARKER  = 2'd0;
   localparam logic [1:0] REG_PHONE_ADDRESS = 2'd1;
   localparam logic [1:0] REG_HOST_ADDRESS  = 2'd2;
   localparam logic [1:0] REG_ACK_TYPE_CODE = 2'd3;

   localparam int ADDR_WIDTH = 4;
   localparam int DATA_WIDTH = 32;

   // register reset values
   localparam logic [7:0] RST_FRAME_MARKER  = 8'd31;
   localparam logic [7:0] RST_PHONE_ADDRESS = 8'd0;
   localparam logic [7:0] RST_HOST_ADDRESS  = 8'd29;
   localparam logic [7:0] RST_ACK_TYPE_CODE = 8'd127;

   typedef struct packed {
      logic [7:0] frame_marker;
      logic [7:0] phone_address;
      logic [7:0] host_address;
      logic [7:0] ack_type_code;
   } cfg_type;

   typedef struct packed {
      logic        has_result;
      logic [2:0]  kind;
      logic [7:0]  data_byte;
      logic [7:0]  msg_type;
      logic [7:0]  source_addr;
      logic [7:0]  sequence_res;
      logic [15:0] msg_length;
   } result_type;

endpackage

// ----- design/xflr_core.sv -----
// frame parser: receive state and the per-byte step logic
module xflr_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           rx_byte,
   input  xflr_pkg::cfg_type    cfg,
   output xflr_pkg::result_type result
);

   logic [2:0]  phase_ff, phase_in;
   logic [7:0]  running_xor_ff, running_xor_in;
   logic [16:0] byte_count_ff, byte_count_in;
   logic [15:0] frame_length_ff, frame_length_in;
   logic [7:0]  frame_type_ff, frame_type_in;
   logic [7:0]  frame_dest_ff, frame_dest_in;
   logic [7:0]  frame_source_ff, frame_source_in;
   logic [7:0]  last_byte_ff;

   logic        known_addr;
   logic [16:0] count_inc;
   logic [16:0] count_end;

   assign known_addr = (rx_byte == cfg.phone_address) || (rx_byte == cfg.host_address);
   assign count_inc  = byte_count_ff + 17'd1;
   assign count_end  = {1'b0, frame_length_ff} + 17'd2;

   always_comb begin
      phase_in        = phase_ff;
      running_xor_in  = running_xor_ff ^ rx_byte;
      byte_count_in   = byte_count_ff;
      frame_length_in = frame_length_ff;
      frame_type_in   = frame_type_ff;
      frame_dest_in   = frame_dest_ff;
      frame_source_in = frame_source_ff;
      result          = '0;

      case (phase_ff)
         xflr_pkg::PH_DEST: begin
            if (!known_addr) begin
               result.has_result = 1'b1;
               result.kind       = xflr_pkg::KIND_ADDR_ERR;
               result.data_byte  = rx_byte;
               phase_in          = xflr_pkg::PH_HUNT;
            end else begin
               frame_dest_in = rx_byte;
               phase_in      = xflr_pkg::PH_SRC;
            end
         end
         xflr_pkg::PH_SRC: begin
            if (!known_addr) begin
               result.has_result = 1'b1;
               result.kind       = xflr_pkg::KIND_ADDR_ERR;
               result.data_byte  = rx_byte;
               phase_in          = xflr_pkg::PH_HUNT;
            end else begin
               frame_source_in = rx_byte;
               phase_in        = xflr_pkg::PH_TYPE;
            end
         end
         xflr_pkg::PH_TYPE: begin
            frame_type_in = rx_byte;
            phase_in      = xflr_pkg::PH_LEN1;
         end
         xflr_pkg::PH_LEN1: begin
            frame_length_in = {rx_byte, 8'h00};
            phase_in        = xflr_pkg::PH_LEN2;
         end
         xflr_pkg::PH_LEN2: begin
            if (frame_type_ff == cfg.ack_type_code) begin
               // short ack frame: the length bytes are sequence and checksum
               result.has_result   = 1'b1;
               result.kind         = xflr_pkg::KIND_ACK_RX;
               result.msg_type     = frame_type_ff;
               result.source_addr  = frame_source_ff;
               result.sequence_res = last_byte_ff;
               phase_in            = xflr_pkg::PH_HUNT;
            end else begin
               frame_length_in = frame_length_ff | {8'h00, rx_byte};
               byte_count_in   = '0;
               phase_in        = xflr_pkg::PH_BODY;
            end
         end
         xflr_pkg::PH_BODY: begin
            byte_count_in = count_inc;
            if (count_inc <= {1'b0, frame_length_ff}) begin
               result.has_result  = 1'b1;
               result.kind        = xflr_pkg::KIND_PAYLOAD;
               result.data_byte   = rx_byte;
               result.msg_type    = frame_type_ff;
               result.source_addr = frame_source_ff;
               result.msg_length  = frame_length_ff;
            end else if (count_inc == count_end) begin
               result.has_result   = 1'b1;
               result.msg_type     = frame_type_ff;
               result.source_addr  = frame_source_ff;
               result.sequence_res = last_byte_ff;
               result.msg_length   = frame_length_ff;
               if (running_xor_ff != rx_byte) begin
                  result.kind = xflr_pkg::KIND_CSUM_ERR;
               end else if (frame_dest_ff != cfg.phone_address) begin
                  result.kind = xflr_pkg::KIND_GOOD;
               end else begin
                  result.kind = xflr_pkg::KIND_IGNORED;
               end
               phase_in = xflr_pkg::PH_HUNT;
            end
         end
         default: begin
            // hunting, and the unused phase code
            if (rx_byte == cfg.frame_marker) begin
               running_xor_in  = cfg.frame_marker;
               byte_count_in   = '0;
               frame_length_in = '0;
               frame_type_in   = '0;
               frame_dest_in   = '0;
               frame_source_in = '0;
               phase_in        = xflr_pkg::PH_DEST;
            end else begin
               phase_in = xflr_pkg::PH_HUNT;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= xflr_pkg::PH_HUNT;
         running_xor_ff  <= '0;
         byte_count_ff   <= '0;
         frame_length_ff <= '0;
         frame_type_ff   <= '0;
         frame_dest_ff   <= '0;
         frame_source_ff <= '0;
         last_byte_ff    <= '0;
      end else if (step) begin
         phase_ff        <= phase_in;
         running_xor_ff  <= running_xor_in;
         byte_count_ff   <= byte_count_in;
         frame_length_ff <= frame_length_in;
         frame_type_ff   <= frame_type_in;
         frame_dest_ff   <= frame_dest_in;
         frame_source_ff <= frame_source_in;
         last_byte_ff    <= rx_byte;
      end
   end

endmodule

// ----- design/xor_framed_link_receiver.sv -----
// top level of the framed link receiver: handshakes, registers, parser
//
//   channel  direction  beat contents
//   req      in         rx_byte, one received link byte
//   rsp      out        kind, data_byte, msg_type, source_addr, sequence_res, msg_length
//   csr      in/out     apb register access, four 8-bit registers at 0x0..0xc
//
// one byte per cycle sustained while rsp_stall is low; a byte lands in the input register
// at its request beat and is parsed there by xflr_core, and its result is
// registered into the result register when the parser advances
// the parse step is one pass of the phase state machine in xflr_core
// reset is synchronous; registers return to their defaults
// rsp_stall holds the result register; req_stall rises only when the byte in
// the input register would produce a result that has nowhere to go
`include "xor_framed_link_receiver_macros.svh"

module xor_framed_link_receiver (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [7:0]                        req_rx_byte,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [2:0]                        rsp_kind,
   output logic [7:0]                        rsp_data_byte,
   output logic [7:0]                        rsp_msg_type,
   output logic [7:0]                        rsp_source_addr,
   output logic [7:0]                        rsp_sequence_res,
   output logic [15:0]                       rsp_msg_length,
   // register port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [xflr_pkg::ADDR_WIDTH-1:0]   paddr,
   input  logic [xflr_pkg::DATA_WIDTH-1:0]   pwdata,
   output logic [xflr_pkg::DATA_WIDTH-1:0]   prdata,
   output logic                              pready
);

   // configuration registers
   xflr_pkg::cfg_type    cfg_ff;
   logic                 cfg_write;
   logic [1:0]           reg_index;
   logic [7:0]           read_byte;

   // input register
   logic                 in_valid_ff;
   logic [7:0]           in_byte_ff;
   logic                 req_accept;

   // parser and result register
   xflr_pkg::result_type core_result;
   xflr_pkg::result_type out_ff;
   logic                 out_valid_ff;
   logic                 out_free;
   logic                 advance;

   // apb: no wait states, register index from the word address
   assign pready    = 1'b1;
   assign reg_index = paddr[3:2];
   assign cfg_write = psel && penable && pwrite && pready;

   always_comb begin
      case (reg_index)
         xflr_pkg::REG_FRAME_MARKER:  read_byte = cfg_ff.frame_marker;
         xflr_pkg::REG_PHONE_ADDRESS: read_byte = cfg_ff.phone_address;
         xflr_pkg::REG_HOST_ADDRESS:  read_byte = cfg_ff.host_address;
         xflr_pkg::REG_ACK_TYPE_CODE: read_byte = cfg_ff.ack_type_code;
         default:                     read_byte = '0;
      endcase
   end

   assign prdata = {{(xflr_pkg::DATA_WIDTH-8){1'b0}}, read_byte};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_marker  <= xflr_pkg::RST_FRAME_MARKER;
         cfg_ff.phone_address <= xflr_pkg::RST_PHONE_ADDRESS;
         cfg_ff.host_address  <= xflr_pkg::RST_HOST_ADDRESS;
         cfg_ff.ack_type_code <= xflr_pkg::RST_ACK_TYPE_CODE;
      end else if (cfg_write) begin
         case (reg_index)
            xflr_pkg::REG_FRAME_MARKER:  cfg_ff.frame_marker  <= pwdata[7:0];
            xflr_pkg::REG_PHONE_ADDRESS: cfg_ff.phone_address <= pwdata[7:0];
            xflr_pkg::REG_HOST_ADDRESS:  cfg_ff.host_address  <= pwdata[7:0];
            xflr_pkg::REG_ACK_TYPE_CODE: cfg_ff.ack_type_code <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   // the held byte moves on when the result slot can take its result, or
   // when it makes no result at all (sync misses, header bytes)
   assign out_free   = !out_valid_ff || !rsp_stall;
   assign advance    = in_valid_ff && (out_free || !core_result.has_result);
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_accept) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   xflr_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (in_byte_ff),
      .cfg     (cfg_ff),
      .result  (core_result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && core_result.has_result) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && core_result.has_result) begin
         out_ff <= core_result;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_kind         = out_ff.kind;
   assign rsp_data_byte    = out_ff.data_byte;
   assign rsp_msg_type     = out_ff.msg_type;
   assign rsp_source_addr  = out_ff.source_addr;
   assign rsp_sequence_res = out_ff.sequence_res;
   assign rsp_msg_length   = out_ff.msg_length;

   // checks on the internal pipeline
   `XFLR_ASSERT_NOW(a_stall_needs_byte, clock, reset, req_stall, in_valid_ff && out_valid_ff)
   `XFLR_ASSERT_NEXT(a_held_byte_stays, clock, reset, in_valid_ff && !advance, in_valid_ff)
   `XFLR_ASSERT_NOW(a_kind_in_range, clock, reset, rsp_valid, rsp_kind <= xflr_pkg::KIND_ADDR_ERR)
   `XFLR_ASSERT_NOW(a_no_length_short, clock, reset, rsp_valid && (rsp_kind == xflr_pkg::KIND_ACK_RX || rsp_kind == xflr_pkg::KIND_ADDR_ERR), rsp_msg_length == 16'd0)

endmodule
